[rtl/etw_pkg.sv]
// ----------------------------------------------------------------------------
// etw_pkg: shared types and constants of the event time window engine
// Item kinds, status codes, window modes and register indexes.
// ----------------------------------------------------------------------------
package etw_pkg;

  localparam int unsigned DefWindowSlots = 8;
  localparam int unsigned DefMaxEvents   = 64;
  localparam int unsigned DefTimeBits    = 48;

  localparam int unsigned RegBits  = 32;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned ValBits  = 32;
  localparam int unsigned AggBits  = 38;
  localparam int unsigned LateBits = 32;

  // item kinds
  localparam logic [1:0] KindEvent   = 2'd0;
  localparam logic [1:0] KindAdvance = 2'd1;
  localparam logic [1:0] KindClose   = 2'd2;
  localparam logic [1:0] KindQuery   = 2'd3;

  // status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatDropped = 2'd1;
  localparam logic [1:0] StatRefused = 2'd2;

  // window modes
  localparam logic [1:0] ModeTumbling = 2'd0;
  localparam logic [1:0] ModeHopping  = 2'd1;
  localparam logic [1:0] ModeSliding  = 2'd2;
  localparam logic [1:0] ModeSession  = 2'd3;

  // aggregate selects
  localparam logic [1:0] AggCount = 2'd0;
  localparam logic [1:0] AggSum   = 2'd1;
  localparam logic [1:0] AggMin   = 2'd2;
  localparam logic [1:0] AggMax   = 2'd3;

  // register indexes
  localparam logic [RegIdxW-1:0] RegMode  = 3'd0;
  localparam logic [RegIdxW-1:0] RegLen   = 3'd1;
  localparam logic [RegIdxW-1:0] RegHop   = 3'd2;
  localparam logic [RegIdxW-1:0] RegGap   = 3'd3;
  localparam logic [RegIdxW-1:0] RegGrace = 3'd4;
  localparam logic [RegIdxW-1:0] RegLimit = 3'd5;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,       // latch the item, start lateness check
    CmdDivStart,   // load the divider
    CmdDivStep,    // one quotient bit
    CmdMulStep,    // one multiply bit, quotient times divisor
    CmdStart,      // form window start from product or timestamp
    CmdSessScan,   // check one slot, newest first
    CmdMatchScan,  // check one slot, oldest first
    CmdCreate,     // append a new slot
    CmdUpdate,     // accumulate the value
    CmdCloseScan,  // close check of one slot
    CmdFinish      // build the result
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } etw_ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       late_drop;
    logic       div_done;
    logic       mul_done;
    logic       scan_last;
    logic       scan_zero;
    logic       scan_hit;
    logic       table_full;
    logic       session_mode;
    logic       tumb_or_hop;
    logic       refused;
  } etw_sts_t;

endpackage

[rtl/etw_datapath.sv]
// ----------------------------------------------------------------------------
// etw_datapath: window table, divider, multiplier and result registers
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module etw_datapath #(
  parameter int unsigned WindowSlots = etw_pkg::DefWindowSlots,
  parameter int unsigned MaxEvents   = etw_pkg::DefMaxEvents,
  parameter int unsigned TimeBits    = etw_pkg::DefTimeBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  etw_pkg::etw_ctl_t                 ctl_i,
  output etw_pkg::etw_sts_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [etw_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  logic [etw_pkg::RegBits-1:0]       cfg_data_i,
  input  logic [1:0]                        in_kind_i,
  input  logic [TimeBits-1:0]               in_time_i,
  input  logic signed [etw_pkg::ValBits-1:0] in_value_i,
  input  logic [TimeBits-1:0]               in_wm_i,
  input  logic [1:0]                        in_agg_sel_i,
  output logic [1:0]                        res_status_o,
  output logic [2:0]                        res_index_o,
  output logic [TimeBits-1:0]               res_wm_o,
  output logic [3:0]                        res_closed_o,
  output logic [etw_pkg::LateBits-1:0]      res_late_o,
  output logic signed [etw_pkg::AggBits-1:0] res_agg_o,
  output logic [3:0]                        res_active_o
);
  import etw_pkg::*;

  localparam int unsigned SlotW = (WindowSlots > 1) ? $clog2(WindowSlots) : 1;
  localparam int unsigned UsedW = $clog2(WindowSlots + 1);
  localparam int unsigned EvW   = $clog2(MaxEvents + 1);
  localparam int unsigned CntW  = $clog2(TimeBits + 1);
  localparam int unsigned CfgEvW = 7;
  localparam int unsigned WideW = TimeBits + 2;

  // configuration registers
  logic [1:0]          mode_q;
  logic [RegBits-1:0]  len_q, hop_q, gap_q, grace_q;
  logic [CfgEvW-1:0]   limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeTumbling;
      len_q   <= RegBits'(60000);
      hop_q   <= RegBits'(30000);
      gap_q   <= RegBits'(30000);
      grace_q <= '0;
      limit_q <= CfgEvW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:  mode_q  <= cfg_data_i[1:0];
        RegLen:   len_q   <= cfg_data_i;
        RegHop:   hop_q   <= cfg_data_i;
        RegGap:   gap_q   <= cfg_data_i;
        RegGrace: grace_q <= cfg_data_i;
        RegLimit: limit_q <= cfg_data_i[CfgEvW-1:0];
        default: ;
      endcase
    end
  end

  // lengths with zero treated as one
  logic [RegBits-1:0] len_eff, hop_eff;
  assign len_eff = (len_q == '0) ? RegBits'(1) : len_q;
  assign hop_eff = (hop_q == '0) ? RegBits'(1) : hop_q;

  // effective limit
  logic [EvW-1:0] lim_eff;
  assign lim_eff = (32'(limit_q) > MaxEvents) ? EvW'(MaxEvents) : EvW'(limit_q);

  // slot table
  logic [TimeBits-1:0]       start_q [WindowSlots];
  logic [TimeBits-1:0]       end_q   [WindowSlots];
  logic                      closed_q[WindowSlots];
  logic [EvW-1:0]            events_q[WindowSlots];
  logic signed [AggBits-1:0] sum_q   [WindowSlots];
  logic signed [ValBits-1:0] min_q   [WindowSlots];
  logic signed [ValBits-1:0] max_q   [WindowSlots];
  logic [UsedW-1:0]          used_q;

  // global state
  logic [TimeBits-1:0] wm_q;
  logic [LateBits-1:0] late_q;

  // item registers
  logic [1:0]                kind_q;
  logic [TimeBits-1:0]       t_q;
  logic signed [ValBits-1:0] v_q;
  logic [1:0]                sel_q;
  logic                      drop_q;

  // divider / multiplier
  logic [TimeBits-1:0] quo_q;
  logic [RegBits:0]    rem_q;
  logic [RegBits-1:0]  dvs_q;
  logic [CntW-1:0]     cnt_q;
  logic [WideW-1:0]    prod_q;
  logic [TimeBits-1:0] mcand_q;

  // scan and placement
  logic [SlotW-1:0]    scan_q;
  logic [TimeBits-1:0] wstart_q;
  logic                hit_q;
  logic [SlotW-1:0]    slot_q;
  logic                refused_q;
  logic [3:0]          closed_cnt_q;

  localparam logic [TimeBits-1:0] TimeMax = '1;

  // scan slot views
  logic [TimeBits:0] sess_lim;
  logic [TimeBits:0] close_lim;
  logic              scan_valid;
  assign scan_valid = ({1'b0, scan_q} < (SlotW+1)'(used_q));
  assign sess_lim   = {1'b0, end_q[scan_q]} + (TimeBits+1)'(gap_q);
  assign close_lim  = {1'b0, end_q[scan_q]} + (TimeBits+1)'(grace_q);

  // divider step
  logic [RegBits:0] rem_sh;
  logic             rem_ge;
  assign rem_sh = {rem_q[RegBits-1:0], quo_q[TimeBits-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  // end of a new slot
  logic [TimeBits:0] end_sum;
  assign end_sum = {1'b0, wstart_q} + (TimeBits+1)'(len_eff);

  // new min and max for update
  logic signed [ValBits-1:0] v_min, v_max;
  assign v_min = (events_q[slot_q] == '0 || v_q < min_q[slot_q]) ? v_q : min_q[slot_q];
  assign v_max = (events_q[slot_q] == '0 || v_q > max_q[slot_q]) ? v_q : max_q[slot_q];

  logic [SlotW-1:0] newest;
  assign newest = SlotW'(used_q - UsedW'(1));

  // datapath sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowSlots; i++) begin
        closed_q[i] <= 1'b0;
        events_q[i] <= '0;
      end
      used_q       <= '0;
      wm_q         <= '0;
      late_q       <= '0;
      kind_q       <= KindEvent;
      drop_q       <= 1'b0;
      cnt_q        <= '0;
      scan_q       <= '0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      refused_q    <= 1'b0;
      closed_cnt_q <= '0;
      res_status_o <= StatOk;
      res_index_o  <= '0;
      res_wm_o     <= '0;
      res_closed_o <= '0;
      res_late_o   <= '0;
      res_agg_o    <= '0;
      res_active_o <= '0;
    end else begin
      case (ctl_i.cmd)
        CmdLoad: begin
          kind_q       <= in_kind_i;
          t_q          <= in_time_i;
          v_q          <= in_value_i;
          sel_q        <= in_agg_sel_i;
          hit_q        <= 1'b0;
          refused_q    <= 1'b0;
          closed_cnt_q <= '0;
          drop_q       <= 1'b0;
          if (in_kind_i == KindEvent && in_time_i < wm_q) begin
            if (late_q != '1) late_q <= late_q + LateBits'(1);
            drop_q <= ((wm_q - in_time_i) > TimeBits'(grace_q));
          end
          if (in_kind_i == KindAdvance && in_wm_i > wm_q) wm_q <= in_wm_i;
          // session scans newest first, others oldest first
          scan_q <= (in_kind_i == KindEvent && mode_q == ModeSession) ? newest : '0;
        end
        CmdDivStart: begin
          quo_q <= t_q;
          rem_q <= '0;
          dvs_q <= (mode_q == ModeTumbling) ? len_eff : hop_eff;
          cnt_q <= '0;
        end
        CmdDivStep: begin
          rem_q <= rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
          quo_q <= {quo_q[TimeBits-2:0], rem_ge};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(TimeBits - 1)) begin
            mcand_q <= '0;
            prod_q  <= '0;
          end
        end
        CmdMulStep: begin
          // shift-add: quotient bits msb first, times divisor
          if (cnt_q == CntW'(TimeBits)) begin
            mcand_q <= quo_q;
            prod_q  <= '0;
            cnt_q   <= '0;
          end else begin
            prod_q  <= (prod_q << 1) +
                       (mcand_q[TimeBits-1] ? WideW'(dvs_q) : WideW'(0));
            mcand_q <= mcand_q << 1;
            cnt_q   <= cnt_q + CntW'(1);
          end
        end
        CmdStart: begin
          case (mode_q)
            ModeTumbling: wstart_q <= prod_q[TimeBits-1:0];
            ModeHopping: begin
              if (prod_q + WideW'(hop_eff) > WideW'(len_eff))
                wstart_q <= TimeBits'(prod_q + WideW'(hop_eff) - WideW'(len_eff));
              else
                wstart_q <= '0;
            end
            ModeSliding: wstart_q <= (t_q > TimeBits'(len_eff)) ?
                                     t_q - TimeBits'(len_eff) : '0;
            default:     wstart_q <= t_q;
          endcase
        end
        CmdSessScan: begin
          if (scan_valid && !closed_q[scan_q] && {1'b0, t_q} <= sess_lim) begin
            hit_q  <= 1'b1;
            slot_q <= scan_q;
            if (t_q > end_q[scan_q]) end_q[scan_q] <= t_q;
          end else if (scan_q == '0) begin
            wstart_q <= t_q;
          end else begin
            scan_q <= scan_q - SlotW'(1);
          end
        end
        CmdMatchScan: begin
          if (scan_valid && !closed_q[scan_q] && start_q[scan_q] == wstart_q) begin
            hit_q  <= 1'b1;
            slot_q <= scan_q;
          end else begin
            scan_q <= scan_q + SlotW'(1);
          end
        end
        CmdCreate: begin
          if (32'(used_q) >= WindowSlots) begin
            refused_q <= 1'b1;
          end else begin
            start_q[used_q[SlotW-1:0]]  <= wstart_q;
            end_q[used_q[SlotW-1:0]]    <= (mode_q == ModeSession) ? t_q :
                                           (end_sum[TimeBits] ? TimeMax :
                                            end_sum[TimeBits-1:0]);
            events_q[used_q[SlotW-1:0]] <= '0;
            closed_q[used_q[SlotW-1:0]] <= 1'b0;
            slot_q <= used_q[SlotW-1:0];
            hit_q  <= 1'b1;
            used_q <= used_q + UsedW'(1);
          end
        end
        CmdUpdate: begin
          if (events_q[slot_q] >= lim_eff) begin
            refused_q <= 1'b1;
          end else begin
            min_q[slot_q]    <= v_min;
            max_q[slot_q]    <= v_max;
            sum_q[slot_q]    <= ((events_q[slot_q] == '0) ? AggBits'(0) : sum_q[slot_q])
                                + AggBits'(v_q);
            events_q[slot_q] <= events_q[slot_q] + EvW'(1);
          end
        end
        CmdCloseScan: begin
          if (scan_valid && !closed_q[scan_q] && close_lim <= {1'b0, wm_q}) begin
            closed_q[scan_q] <= 1'b1;
            closed_cnt_q     <= closed_cnt_q + 4'd1;
          end
          scan_q <= scan_q + SlotW'(1);
        end
        CmdFinish: begin
          res_wm_o     <= wm_q;
          res_late_o   <= late_q;
          res_active_o <= 4'(used_q);
          res_closed_o <= (kind_q == KindClose) ? closed_cnt_q : 4'd0;
          res_status_o <= StatOk;
          res_index_o  <= '0;
          res_agg_o    <= '0;
          if (kind_q == KindEvent) begin
            if (drop_q)         res_status_o <= StatDropped;
            else if (refused_q) res_status_o <= StatRefused;
            else                res_index_o  <= 3'(slot_q);
          end
          if (kind_q == KindQuery && used_q != '0 && events_q[newest] != '0) begin
            case (sel_q)
              AggCount: res_agg_o <= AggBits'(events_q[newest]);
              AggSum:   res_agg_o <= sum_q[newest];
              AggMin:   res_agg_o <= AggBits'(min_q[newest]);
              default:  res_agg_o <= AggBits'(max_q[newest]);
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts_o.kind         = kind_q;
    sts_o.late_drop    = drop_q;
    sts_o.div_done     = (cnt_q == CntW'(TimeBits));
    sts_o.mul_done     = (cnt_q == CntW'(TimeBits - 1));
    sts_o.scan_last    = ({1'b0, scan_q} + (SlotW+1)'(1) >= (SlotW+1)'(used_q));
    sts_o.scan_zero    = (scan_q == '0);
    sts_o.scan_hit     = hit_q;
    sts_o.table_full   = (32'(used_q) >= WindowSlots);
    sts_o.session_mode = (mode_q == ModeSession);
    sts_o.tumb_or_hop  = (mode_q == ModeTumbling) || (mode_q == ModeHopping);
    sts_o.refused      = refused_q;
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= WindowSlots) else $error("slot count beyond table");
  a_wm_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wm_q >= $past(wm_q)) else $error("watermark went back");
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == $past(used_q) || used_q == $past(used_q) + UsedW'(1))
    else $error("slot count jumped");
`endif

endmodule

[rtl/etw_ctrl.sv]
// ----------------------------------------------------------------------------
// etw_ctrl: sequencer of the event time window engine
// Steps items through their divide, scan, update, close and result phases.
// ----------------------------------------------------------------------------
module etw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output etw_pkg::etw_ctl_t ctl_o,
  input  etw_pkg::etw_sts_t sts_i
);
  import etw_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StDecide, StDivStart, StDiv, StMul, StStart, StSess,
    StMatch, StCreate, StUpdate, StClose, StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_e   cmd;

  // result register frees as soon as taken
  logic out_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // next state and command
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = CmdNone;
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd = CmdLoad; state_d = StDecide;
      end
      StDecide: begin
        if (sts_i.kind == KindEvent && !sts_i.late_drop) begin
          if (sts_i.session_mode)     state_d = StSess;
          else if (sts_i.tumb_or_hop) state_d = StDivStart;
          else                        state_d = StStart;
        end else if (sts_i.kind == KindClose) state_d = StClose;
        else state_d = StFinish;
      end
      StDivStart: begin cmd = CmdDivStart; state_d = StDiv; end
      StDiv: begin
        cmd = CmdDivStep;
        if (sts_i.mul_done) state_d = StMul;
      end
      StMul: begin
        cmd = CmdMulStep;
        if (sts_i.mul_done) state_d = StStart;
      end
      StStart: begin cmd = CmdStart; state_d = StMatch; end
      StSess: begin
        cmd = CmdSessScan;
        if (sts_i.scan_hit)       state_d = StUpdate;
        else if (sts_i.scan_zero) state_d = StMatch;
      end
      StMatch: begin
        cmd = CmdMatchScan;
        if (sts_i.scan_hit)       state_d = StUpdate;
        else if (sts_i.scan_last) state_d = StCreate;
      end
      StCreate: begin
        if (sts_i.scan_hit)      state_d = StUpdate;
        else if (sts_i.refused)  state_d = StFinish;
        else                     cmd = CmdCreate;
      end
      StUpdate: begin cmd = CmdUpdate; state_d = StFinish; end
      StClose: begin
        cmd = CmdCloseScan;
        if (sts_i.scan_last) state_d = StFinish;
      end
      StFinish: if (out_free) begin
        cmd = CmdFinish; out_valid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign ctl_o.cmd = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("result lost");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && in_valid_i |=> !in_ready_o) else $error("second item taken");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == CmdFinish |=> out_valid_q) else $error("finish without result");
`endif

endmodule

[rtl/event_time_window_engine.sv]
// ----------------------------------------------------------------------------
// event_time_window_engine: event time windowing with watermark
// Assigns events to windows and keeps count, sum, min and max per window.
// ----------------------------------------------------------------------------
// Flow: an advance, query or dropped event goes straight to the result; a close
// first scans the slots in use; a tumbling or hopping event first runs the
// bit-serial divider and multiplier, then the slot scan and update.
// One item at a time: the next input transaction is taken the cycle after the
// result is loaded; the bit-serial divider and multiplier set the pace.
// Reset: asynchronous active low, empties the window table and clears results.
module event_time_window_engine #(
  parameter int unsigned WindowSlots = etw_pkg::DefWindowSlots,
  parameter int unsigned MaxEvents   = etw_pkg::DefMaxEvents,
  parameter int unsigned TimeBits    = etw_pkg::DefTimeBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [etw_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [etw_pkg::RegBits-1:0] cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // kind, timestamp, value, new watermark, aggregate select
  input  logic [((2*TimeBits+36+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status, window_index, watermark, closed_count, late_total,
  // aggregate_value, active_windows
  output logic [((TimeBits+83+7)/8)*8-1:0] m_axis_tdata
);
  import etw_pkg::*;

  localparam int unsigned InW  = ((2*TimeBits+36+7)/8)*8;
  localparam int unsigned OutW = ((TimeBits+83+7)/8)*8;

  etw_ctl_t ctl;
  etw_sts_t sts;

  logic [1:0]                res_status;
  logic [2:0]                res_index;
  logic [TimeBits-1:0]       res_wm;
  logic [3:0]                res_closed;
  logic [LateBits-1:0]       res_late;
  logic signed [AggBits-1:0] res_agg;
  logic [3:0]                res_active;

  etw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  etw_datapath #(
    .WindowSlots(WindowSlots), .MaxEvents(MaxEvents), .TimeBits(TimeBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_kind_i   (s_axis_tdata[1:0]),
    .in_time_i   (s_axis_tdata[2 +: TimeBits]),
    .in_value_i  (s_axis_tdata[2+TimeBits +: ValBits]),
    .in_wm_i     (s_axis_tdata[2+TimeBits+ValBits +: TimeBits]),
    .in_agg_sel_i(s_axis_tdata[2+2*TimeBits+ValBits +: 2]),
    .res_status_o(res_status),
    .res_index_o (res_index),
    .res_wm_o    (res_wm),
    .res_closed_o(res_closed),
    .res_late_o  (res_late),
    .res_agg_o   (res_agg),
    .res_active_o(res_active)
  );

  assign m_axis_tdata = OutW'({res_active, res_agg, res_late, res_closed,
                               res_wm, res_index, res_status});

  logic unused_in;
  assign unused_in = ^s_axis_tdata[InW-1:2*TimeBits+ValBits+4];

endmodule
